### sv/htb_pkg.sv
// huffman tree block package: item types and kind codes
// no dependencies
package htb_pkg;
	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_ENC = 2'd1;
	localparam logic [1:0] KIND_DEC = 2'd2;
	localparam logic [1:0] KIND_RSVD = 2'd3;
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] symbol_in;
		logic [15:0] leaf_weight;
		logic last_leaf;
		logic code_bit;
	} in_item_t;
	typedef struct packed {
		logic [7:0] decoded_symbol;
		logic [62:0] code_value;
		logic [5:0] code_length;
		logic found;
	} out_item_t;
endpackage

### sv/htb_ram.sv
// generic single write, single registered read memory
// no dependencies
module htb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### sv/huffman_tree_build_encode_decode.sv
// huffman tree build, encode and decode; uses htb_pkg and htb_ram
// load: writes one leaf; the last load of n leaves starts a clearing pass over
// nodes 0..2n-2 and n-1 merges, merge i scans nodes 0..i-1
// encode: leaf search, then one code bit per step up the tree to the root
// decode: one tree step per bit, symbol read at a leaf; reset clears counters,
// node memories stay undefined; one item at a time, in_stall high while busy
// or while a result waits
module huffman_tree_build_encode_decode
	import htb_pkg::*;
#(
	parameter int MAX_LEAVES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_data
);
	localparam int NS = 2 * MAX_LEAVES - 1;
	localparam int NW = $clog2(NS + 1);
	localparam int LW = $clog2(MAX_LEAVES + 1);
	localparam int LA = $clog2(MAX_LEAVES);
	localparam int WW = 16 + NW;

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_CLR = 14'b00000000000010,
		S_SCAN = 14'b00000000000100,
		S_SCAN2 = 14'b00000000001000,
		S_MERGE = 14'b00000000010000,
		S_SRCH = 14'b00000000100000,
		S_SRCH2 = 14'b00000001000000,
		S_WALK = 14'b00000010000000,
		S_WALK2 = 14'b00000100000000,
		S_WALK3 = 14'b00001000000000,
		S_DEC = 14'b00010000000000,
		S_DEC2 = 14'b00100000000000,
		S_DEC3 = 14'b01000000000000,
		S_DEC4 = 14'b10000000000000
	} state_t;
	state_t state_q;

	logic [LW-1:0] leaf_count_q;
	logic [NW-1:0] decode_node_q;
	logic tree_ready_q;
	logic [NW-1:0] i_q, j_q, s1_q, s2_q, c_q;
	logic [1:0] seen_q;
	logic [WW-1:0] w1_q, w2_q;
	logic [62:0] code_q;
	logic [5:0] len_q;
	logic [7:0] sym_q;
	logic bit_q;
	out_item_t res_q;
	logic out_valid_q;

	// memory ports
	logic w_we, p_we, l_we, r_we, s_we;
	logic [NW-1:0] w_wa, p_wa, l_wa, r_wa, rd_a;
	logic [WW-1:0] w_wd, w_rd;
	logic [NW-1:0] p_wd, l_wd, r_wd, p_rd, l_rd, r_rd;
	logic [LA-1:0] s_wa, s_ra;
	logic [7:0] s_wd, s_rd;

	htb_ram #(.WIDTH(WW), .DEPTH(NS+1)) u_w (.clk, .we(w_we), .waddr(w_wa),
		.wdata(w_wd), .raddr(rd_a), .rdata(w_rd));
	htb_ram #(.WIDTH(NW), .DEPTH(NS+1)) u_p (.clk, .we(p_we), .waddr(p_wa),
		.wdata(p_wd), .raddr(rd_a), .rdata(p_rd));
	htb_ram #(.WIDTH(NW), .DEPTH(NS+1)) u_l (.clk, .we(l_we), .waddr(l_wa),
		.wdata(l_wd), .raddr(rd_a), .rdata(l_rd));
	htb_ram #(.WIDTH(NW), .DEPTH(NS+1)) u_r (.clk, .we(r_we), .waddr(r_wa),
		.wdata(r_wd), .raddr(rd_a), .rdata(r_rd));
	htb_ram #(.WIDTH(8), .DEPTH(MAX_LEAVES)) u_s (.clk, .we(s_we), .waddr(s_wa),
		.wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

	logic [NW-1:0] lc_n, total_m1, nx;
	logic [LW-1:0] lc_eff;
	logic lc_full;
	assign lc_n = NW'(leaf_count_q);
	assign total_m1 = NW'(2 * lc_n - NW'(2));
	assign in_stall = (state_q != S_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = res_q;
	assign nx = bit_q ? r_rd : l_rd;

	// load path: count after possible restart
	assign lc_eff = tree_ready_q ? '0 : leaf_count_q;
	assign lc_full = (lc_eff >= LW'(MAX_LEAVES));

	logic take;
	assign take = in_valid && !in_stall;

	// parent write of the second picked node, the cycle after a merge
	logic p2_q;

	// memory port control
	always_comb begin
		w_we = 1'b0; p_we = 1'b0; l_we = 1'b0; r_we = 1'b0; s_we = 1'b0;
		w_wa = i_q; p_wa = j_q; l_wa = i_q; r_wa = i_q;
		w_wd = w1_q + w2_q; p_wd = '0; l_wd = s1_q; r_wd = s2_q;
		s_wa = LA'(lc_eff); s_wd = in_data.symbol_in;
		rd_a = j_q; s_ra = LA'(j_q);
		case (state_q)
			S_IDLE: begin
				if (take && in_data.kind == KIND_LOAD && !lc_full) begin
					w_we = 1'b1; s_we = 1'b1;
					w_wa = NW'(lc_eff);
					w_wd = WW'(in_data.leaf_weight);
				end
				rd_a = decode_node_q;
			end
			S_CLR: begin
				p_we = 1'b1; l_we = 1'b1; r_we = 1'b1;
				l_wa = j_q; r_wa = j_q; l_wd = '0; r_wd = '0;
			end
			S_MERGE: begin
				w_we = 1'b1; l_we = 1'b1; r_we = 1'b1; p_we = 1'b1;
				p_wa = s1_q; p_wd = i_q;
			end
			S_WALK: rd_a = c_q;
			// fetch children of the parent just read
			S_WALK2: rd_a = p_rd;
			S_DEC, S_DEC2: rd_a = decode_node_q;
			default: ;
		endcase
		// i_q has already moved to the next node here
		if (p2_q) begin
			p_we = 1'b1;
			p_wa = s2_q;
			p_wd = i_q - NW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			leaf_count_q <= '0;
			decode_node_q <= '0;
			tree_ready_q <= 1'b0;
			out_valid_q <= 1'b0;
			p2_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			p2_q <= (state_q == S_MERGE);
			case (state_q)
				S_IDLE: begin
					if (take) begin
						sym_q <= in_data.symbol_in;
						bit_q <= in_data.code_bit;
						res_q <= '0;
						case (in_data.kind)
							KIND_LOAD: begin
								if (tree_ready_q) begin
									tree_ready_q <= 1'b0;
									decode_node_q <= '0;
								end
								if (in_data.last_leaf) begin
									if (LW'(lc_eff + LW'(!lc_full)) >= LW'(2)) begin
										leaf_count_q <= LW'(lc_eff + LW'(!lc_full));
										j_q <= '0;
										state_q <= S_CLR;
									end else begin
										leaf_count_q <= '0;
									end
								end else begin
									leaf_count_q <= LW'(lc_eff + LW'(!lc_full));
								end
							end
							KIND_ENC: begin
								if (!tree_ready_q) begin
									out_valid_q <= 1'b1;
								end else begin
									j_q <= '0;
									state_q <= S_SRCH;
								end
							end
							KIND_DEC: begin
								if (tree_ready_q && decode_node_q < NW'(NS))
									state_q <= S_DEC;
							end
							default: ;
						endcase
					end
				end
				S_CLR: begin
					if (j_q == total_m1) begin
						i_q <= lc_n;
						j_q <= '0;
						seen_q <= '0;
						state_q <= S_SCAN;
					end else begin
						j_q <= j_q + NW'(1);
					end
				end
				S_SCAN: state_q <= S_SCAN2; // read latency
				S_SCAN2: begin
					if (j_q == i_q) begin
						// all nodes below i scanned; go merge
						state_q <= S_MERGE;
					end else begin
						if (p_rd == '0) begin
							if (seen_q == 2'd0) begin
								s1_q <= j_q; w1_q <= w_rd; seen_q <= 2'd1;
							end else if (seen_q == 2'd1) begin
								s2_q <= j_q; w2_q <= w_rd; seen_q <= 2'd2;
							end else begin
								if (w_rd < w2_q && w_rd < w1_q) begin
									if (w2_q <= w1_q) begin
										s1_q <= j_q; w1_q <= w_rd;
									end else begin
										s2_q <= j_q; w2_q <= w_rd;
									end
								end
								if (w_rd < w2_q && w_rd > w1_q) begin
									s2_q <= j_q; w2_q <= w_rd;
								end
								if (w_rd < w1_q && w_rd > w2_q) begin
									s1_q <= j_q; w1_q <= w_rd;
								end
							end
						end
						j_q <= j_q + NW'(1);
						state_q <= S_SCAN;
					end
				end
				S_MERGE: begin
					// parent of s1 written now, parent of s2 next cycle via p2
					j_q <= '0;
					i_q <= i_q + NW'(1);
					seen_q <= '0;
					if (i_q == total_m1) begin
						tree_ready_q <= 1'b1;
						decode_node_q <= total_m1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SRCH: state_q <= S_SRCH2;
				S_SRCH2: begin
					if (s_rd == sym_q) begin
						c_q <= j_q; code_q <= '0; len_q <= '0;
						state_q <= S_WALK;
					end else if (j_q + NW'(1) >= lc_n) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						j_q <= j_q + NW'(1);
						state_q <= S_SRCH;
					end
				end
				S_WALK: state_q <= S_WALK2; // read parent of c
				S_WALK2: begin
					if (p_rd == '0) begin
						res_q.code_value <= code_q;
						res_q.code_length <= len_q;
						res_q.found <= 1'b1;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						c_q <= p_rd;
						state_q <= S_WALK3;
					end
				end
				S_WALK3: begin
					// left child of parent now read; prev child kept in j_q
					if (len_q < 6'd63) begin
						code_q <= code_q | (63'(l_rd != j_q) << len_q);
						len_q <= len_q + 6'd1;
					end else begin
						code_q <= (code_q >> 1) | (63'(l_rd != j_q) << 62);
					end
					j_q <= c_q;
					state_q <= S_WALK;
				end
				S_DEC: state_q <= S_DEC2;
				S_DEC2: begin
					if (nx < lc_n) begin
						j_q <= nx;
						state_q <= S_DEC3;
					end else begin
						decode_node_q <= (nx >= NW'(NS)) ? '0 : nx;
						state_q <= S_IDLE;
					end
				end
				S_DEC3: state_q <= S_DEC4;
				S_DEC4: begin
					res_q.decoded_symbol <= s_rd;
					res_q.found <= 1'b1;
					out_valid_q <= 1'b1;
					decode_node_q <= total_m1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### tb/sv/tb_top.sv
// testbench for the huffman tree build, encode and decode block
// uses htb_pkg and huffman_tree_build_encode_decode; self-checking, no files
`timescale 1ns / 100ps

module tb_top;
	import htb_pkg::*;

	localparam int LEAF_CAP = 64;
	localparam int SLOTS = 2 * LEAF_CAP - 1;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;

	huffman_tree_build_encode_decode #(.MAX_LEAVES(LEAF_CAP)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// predictor state, mirrors the block's tables
	logic [21:0] p_weight [SLOTS];
	logic [6:0] p_parent [SLOTS];
	logic [6:0] p_left [SLOTS];
	logic [6:0] p_right [SLOTS];
	logic [7:0] p_sym [LEAF_CAP];
	int unsigned p_count = 0;
	int unsigned p_dec_node = 0;
	bit p_ready = 0;

	in_item_t pending_items[$];
	out_item_t expected_results[$];
	int errors = 0;
	int n_results = 0;
	int n_accepted = 0;
	bit quiet;        // no idling in the last part of the run
	bit hold_req;     // asks the monitor for one long hold-off
	bit hold_done;
	int hold_cycles;  // long receiver hold-off, counted by the monitor
	int tree_count = 0;

	// two-slot parentless node pick over 0..lim-1, with its odd tie rule
	function automatic void pick_pair(input int unsigned lim, output int unsigned a,
			output int unsigned b);
		int unsigned s1, s2, seen;
		logic [21:0] w1, w2, w3;
		s1 = 0;
		s2 = 0;
		seen = 0;
		for (int unsigned j = 0; j < lim; j++) begin
			if (p_parent[j] != 0)
				continue;
			seen++;
			if (seen == 1) begin
				s1 = j;
			end else if (seen == 2) begin
				s2 = j;
			end else begin
				w3 = p_weight[j];
				w1 = p_weight[s1];
				w2 = p_weight[s2];
				if (w3 < w2 && w3 < w1) begin
					if (w2 <= w1) s1 = j; else s2 = j;
				end
				if (w3 < w2 && w3 > w1) s2 = j;
				if (w3 < w1 && w3 > w2) s1 = j;
			end
		end
		a = s1;
		b = s2;
	endfunction

	function automatic void build_tree();
		int unsigned total, a, b;
		total = 2 * p_count - 1;
		for (int unsigned i = 0; i < total; i++) begin
			p_parent[i] = '0;
			p_left[i] = '0;
			p_right[i] = '0;
		end
		for (int unsigned i = p_count; i < total; i++) begin
			pick_pair(i, a, b);
			p_parent[a] = 7'(i);
			p_parent[b] = 7'(i);
			p_left[i] = 7'(a);
			p_right[i] = 7'(b);
			p_weight[i] = p_weight[a] + p_weight[b];
		end
		p_ready = 1;
		p_dec_node = total - 1;
		tree_count++;
	endfunction

	// apply one accepted item to the predictor, queue any result it causes
	function automatic void predict_item(input in_item_t it);
		out_item_t r;
		int unsigned i, c, f, len, nx;
		logic [62:0] code;
		bit hit;
		r = '0;
		case (it.kind)
			KIND_LOAD: begin
				if (p_ready) begin
					p_ready = 0;
					p_count = 0;
					p_dec_node = 0;
				end
				if (p_count < LEAF_CAP) begin
					p_sym[p_count] = it.symbol_in;
					p_weight[p_count] = 22'(it.leaf_weight);
					p_count++;
				end
				if (it.last_leaf) begin
					if (p_count >= 2) build_tree();
					else p_count = 0;
				end
			end
			KIND_ENC: begin
				if (p_ready) begin
					hit = 0;
					for (i = 0; i < p_count; i++) begin
						if (p_sym[i] == it.symbol_in) begin
							hit = 1;
							break;
						end
					end
					if (hit) begin
						code = '0;
						len = 0;
						c = i;
						f = p_parent[c];
						while (f != 0) begin
							code[len] = (p_left[f] == c) ? 1'b0 : 1'b1;
							len++;
							c = f;
							f = p_parent[c];
						end
						r.code_value = code;
						r.code_length = 6'(len);
						r.found = 1'b1;
					end
				end
				expected_results.push_back(r);
			end
			KIND_DEC: begin
				if (p_ready) begin
					nx = it.code_bit ? p_right[p_dec_node] : p_left[p_dec_node];
					if (nx < p_count) begin
						r.decoded_symbol = p_sym[nx];
						r.found = 1'b1;
						expected_results.push_back(r);
						p_dec_node = 2 * p_count - 2;
					end else begin
						p_dec_node = nx;
					end
				end
			end
			default: ;
		endcase
	endfunction

	// clock
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// driver: offers queued items, random gap bursts while not quiet
	int gap_left;
	bit pause_req;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_item(in_data);
				n_accepted++;
			end
			if (in_valid && in_stall) begin
				// hold payload while stalled
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pause_req && expected_results.size() != 0) begin
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				if (!quiet && $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(1, 8) - 1;
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: checks results, random stall bursts and one long hold-off
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			hold_cycles = 0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (expected_results.size() == 0) begin
					$error("result with nothing expected: %p", out_data);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (out_data.decoded_symbol !== e.decoded_symbol) begin
						$error("decoded_symbol exp %0d got %0d", e.decoded_symbol,
							out_data.decoded_symbol);
						errors++;
					end
					if (out_data.code_value !== e.code_value) begin
						$error("code_value exp %h got %h", e.code_value, out_data.code_value);
						errors++;
					end
					if (out_data.code_length !== e.code_length) begin
						$error("code_length exp %0d got %0d", e.code_length,
							out_data.code_length);
						errors++;
					end
					if (out_data.found !== e.found) begin
						$error("found exp %0d got %0d", e.found, out_data.found);
						errors++;
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_cycles = 400;
				hold_done = 1;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 8) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic in_item_t mk(input logic [1:0] k, input logic [7:0] s,
			input logic [15:0] w, input logic l, input logic b);
		in_item_t it;
		it.kind = k;
		it.symbol_in = s;
		it.leaf_weight = w;
		it.last_leaf = l;
		it.code_bit = b;
		return it;
	endfunction

	// queue a table of n leaves with random content, symbols from a small pool
	// when dup is set so duplicates appear
	task automatic add_table(input int n, input bit dup);
		logic [15:0] w;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: w = 16'($urandom_range(0, 3));
				1: w = 16'hffff;
				default: w = 16'($urandom);
			endcase
			pending_items.push_back(mk(KIND_LOAD,
				dup ? 8'($urandom_range(0, 7)) : 8'($urandom), w, i == n - 1,
				1'($urandom)));
		end
	endtask

	task automatic add_queries(input int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: pending_items.push_back(mk(KIND_ENC,
					($urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom)),
					16'($urandom), 1'($urandom), 1'($urandom)));
				9: pending_items.push_back(mk(KIND_RSVD, 8'($urandom), 16'($urandom),
					1'($urandom), 1'($urandom)));
				default: pending_items.push_back(mk(KIND_DEC, 8'($urandom),
					16'($urandom), 1'($urandom), 1'($urandom)));
			endcase
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 0;
		quiet = 0;
		hold_req = 0;
		pause_req = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// directed: queries before any tree, short tables, extremes
		pending_items.push_back(mk(KIND_ENC, 8'd0, 16'd0, 1'b0, 1'b0));
		pending_items.push_back(mk(KIND_DEC, 8'd0, 16'd0, 1'b0, 1'b1));
		pending_items.push_back(mk(KIND_RSVD, 8'hff, 16'hffff, 1'b1, 1'b1));
		// single leaf marked last: table discarded
		pending_items.push_back(mk(KIND_LOAD, 8'd5, 16'd9, 1'b1, 1'b0));
		pending_items.push_back(mk(KIND_ENC, 8'd5, 16'd0, 1'b0, 1'b0));
		// two leaves with extreme weights and symbols
		pending_items.push_back(mk(KIND_LOAD, 8'd0, 16'hffff, 1'b0, 1'b0));
		pending_items.push_back(mk(KIND_LOAD, 8'hff, 16'd0, 1'b1, 1'b1));
		pending_items.push_back(mk(KIND_ENC, 8'hff, 16'd0, 1'b0, 1'b0));
		pending_items.push_back(mk(KIND_ENC, 8'd0, 16'd0, 1'b0, 1'b0));
		pending_items.push_back(mk(KIND_ENC, 8'd7, 16'd0, 1'b0, 1'b0));
		pending_items.push_back(mk(KIND_DEC, 8'd0, 16'd0, 1'b0, 1'b0));
		pending_items.push_back(mk(KIND_DEC, 8'd0, 16'd0, 1'b0, 1'b1));
		// equal weights with duplicate symbols, exercises the tie rule
		for (int i = 0; i < 5; i++)
			pending_items.push_back(mk(KIND_LOAD, 8'(i % 3), 16'd4, i == 4, 1'b0));
		for (int i = 0; i < 3; i++)
			pending_items.push_back(mk(KIND_ENC, 8'(i), 16'd0, 1'b0, 1'b0));
		wait_drained();

		// full table with overflow loads, last mark on a dropped leaf;
		// geometric weights give a deep tree
		for (int i = 0; i < LEAF_CAP + 3; i++)
			pending_items.push_back(mk(KIND_LOAD, 8'(i), 16'(i < 16 ? (1 << i) : 16'hffff),
				i == LEAF_CAP + 2, 1'b0));
		pending_items.push_back(mk(KIND_ENC, 8'd0, 16'd0, 1'b0, 1'b0));
		pending_items.push_back(mk(KIND_ENC, 8'd63, 16'd0, 1'b0, 1'b0));
		pending_items.push_back(mk(KIND_ENC, 8'd64, 16'd0, 1'b0, 1'b0));
		for (int i = 0; i < 40; i++)
			pending_items.push_back(mk(KIND_DEC, 8'($urandom), 16'($urandom),
				1'($urandom), 1'($urandom)));
		wait_drained();

		// receiver holds off while sender keeps going, input should back up
		hold_req = 1;
		add_queries(30);
		wait_drained();

		// sender pause until everything has come back
		pause_req = 1;
		add_table(6, 1);
		add_queries(20);
		wait_drained();
		pause_req = 0;

		// random phase: mostly well-formed tables with queries after them
		while (n_accepted < 600) begin
			if ($urandom_range(0, 9) == 0)
				add_table($urandom_range(1, 3), 1'($urandom_range(0, 1)));
			else
				add_table($urandom_range(2, 12), 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 19) == 0)
				add_table(LEAF_CAP, 1'b0);
			add_queries($urandom_range(5, 40));
			if (n_accepted > 480)
				quiet = 1;
			wait_drained();
		end
		repeat (200) @(posedge clk);
		$display("covered %0d items, %0d results, %0d trees built", n_accepted, n_results,
			tree_count);
		if (errors == 0 && expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule

### files.f
sv/htb_pkg.sv
sv/htb_ram.sv
sv/huffman_tree_build_encode_decode.sv
tb/sv/tb_top.sv
